// ----- hdl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, sampled on clock, off during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/tbe_pkg.sv -----
// ---------------------------------------------------------------------------
// tbe_pkg
// Types and constants shared by the task budget enforcer modules.
// ---------------------------------------------------------------------------
package tbe_pkg;

   // Event modes; code 7 is unused and changes nothing
   typedef enum logic [2:0] {
      MODE_FIRST_JOB       = 3'd0,
      MODE_BOUNDARY_SLEEP  = 3'd1,
      MODE_BOUNDARY_PREDICT = 3'd2,
      MODE_SCHED_IN        = 3'd3,
      MODE_SCHED_OUT       = 3'd4,
      MODE_CHECK           = 3'd5,
      MODE_REFRESH         = 3'd6
   } mode_type;

   // Configuration register indexes
   localparam logic [1:0] CSR_PERIOD_BUDGET      = 2'd0;
   localparam logic [1:0] CSR_THROTTLE_THRESHOLD = 2'd1;

   localparam logic [31:0] RESET_THRESHOLD = 32'd5000;

   // Budget check outcome, check unit to core
   typedef struct packed {
      logic [62:0] remaining;
      logic        timer_arm;
      logic [62:0] timer_reload;
      logic        sleep_req;
      logic        throttle_set;
      logic [31:0] overuse_tally;
      logic [62:0] overuse_peak;
   } chk_type;

   // One result transaction
   typedef struct packed {
      logic [62:0] remaining_budget;
      logic        timer_arm;
      logic [62:0] timer_reload;
      logic        sleep_request;
      logic        wake_request;
      logic        throttled;
      logic [63:0] job_runtime;
      logic [63:0] job_count_used;
      logic [63:0] period_used_so_far;
      logic [63:0] consumed_total;
      logic [31:0] overuse_events;
      logic [62:0] worst_overuse;
   } rsp_type;

endpackage

// ----- hdl/task_budget_enforcer.sv -----
// ---------------------------------------------------------------------------
// task_budget_enforcer
// Per-task CPU budget accounting and throttling, one event per transaction.
// ---------------------------------------------------------------------------
//  Channel  Dir  Handshake           Payload
//  req_     in   req_valid/req_stall mode, now_time, now_count, work_pending
//  rsp_     out  rsp_valid/rsp_stall twelve result fields
//  csr_     in   csr_valid/csr_ready csr_index, csr_data
//
//  One transaction per cycle sustained while the result is not stalled; an
//  accepted event passes the input register, then the result register.
//  Reset is synchronous and active high: task sleeping, not throttled,
//  all stamps, totals and statistics zero, threshold 5000, budget zero.
//  A held result stalls the input register, which then raises req_stall.
//  csr_ready is always high.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module task_budget_enforcer (
   input  logic        clock,
   input  logic        reset,
   // event channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_mode,
   input  logic [63:0] req_now_time,
   input  logic [63:0] req_now_count,
   input  logic        req_work_pending,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [62:0] rsp_remaining_budget,
   output logic        rsp_timer_arm,
   output logic [62:0] rsp_timer_reload,
   output logic        rsp_sleep_request,
   output logic        rsp_wake_request,
   output logic        rsp_throttled,
   output logic [63:0] rsp_job_runtime,
   output logic [63:0] rsp_job_count_used,
   output logic [63:0] rsp_period_used_so_far,
   output logic [63:0] rsp_consumed_total,
   output logic [31:0] rsp_overuse_events,
   output logic [62:0] rsp_worst_overuse,
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);
   import tbe_pkg::*;

   logic        in_valid_ff, in_valid_in;
   logic [2:0]  mode_ff;
   logic [63:0] time_ff;
   logic [63:0] count_ff;
   logic        pending_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff;
   rsp_type     core_rsp;
   logic [62:0] budget_ff;
   logic [31:0] threshold_ff;
   logic        out_free;
   logic        out_load;
   logic        req_accept;

   // Handshake control
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign out_load     = in_valid_ff && out_free;
   assign req_stall    = in_valid_ff && !out_free;
   assign req_accept   = req_valid && !req_stall;
   assign in_valid_in  = req_accept || (in_valid_ff && !out_free);
   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);
   assign csr_ready    = 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff    <= 63'd0;
         threshold_ff <= RESET_THRESHOLD;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PERIOD_BUDGET:      budget_ff    <= csr_data[62:0];
            CSR_THROTTLE_THRESHOLD: threshold_ff <= csr_data[31:0];
            default: begin
            end
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         mode_ff    <= req_mode;
         time_ff    <= req_now_time;
         count_ff   <= req_now_count;
         pending_ff <= req_work_pending;
      end
   end

   tbe_core u_core (
      .clock         (clock),
      .reset         (reset),
      .fire          (out_load),
      .mode          (mode_ff),
      .now_time      (time_ff),
      .now_count     (count_ff),
      .work_pending  (pending_ff),
      .period_budget (budget_ff),
      .threshold     (threshold_ff),
      .rsp           (core_rsp)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_ff <= core_rsp;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_remaining_budget   = rsp_ff.remaining_budget;
   assign rsp_timer_arm          = rsp_ff.timer_arm;
   assign rsp_timer_reload       = rsp_ff.timer_reload;
   assign rsp_sleep_request      = rsp_ff.sleep_request;
   assign rsp_wake_request       = rsp_ff.wake_request;
   assign rsp_throttled          = rsp_ff.throttled;
   assign rsp_job_runtime        = rsp_ff.job_runtime;
   assign rsp_job_count_used     = rsp_ff.job_count_used;
   assign rsp_period_used_so_far = rsp_ff.period_used_so_far;
   assign rsp_consumed_total     = rsp_ff.consumed_total;
   assign rsp_overuse_events     = rsp_ff.overuse_events;
   assign rsp_worst_overuse      = rsp_ff.worst_overuse;

   `ASSERT_NEXT(a_held_event_kept, in_valid_ff && !out_free, in_valid_ff, "stalled event dropped")
   `ASSERT_IMPLY(a_arm_no_sleep, rsp_valid_ff && rsp_ff.timer_arm, !rsp_ff.sleep_request && (rsp_ff.remaining_budget != 63'd0), "timer armed with sleep or zero budget")
   `ASSERT_IMPLY(a_sleep_throttled, rsp_valid_ff && rsp_ff.sleep_request, rsp_ff.throttled && !rsp_ff.wake_request, "sleep request without throttle")

endmodule

// ----- hdl/tbe_budget_check.sv -----
// ---------------------------------------------------------------------------
// tbe_budget_check
// Remaining budget, throttle decision and overuse statistics for one event.
// ---------------------------------------------------------------------------
module tbe_budget_check (
   input  logic [63:0]     run_time,
   input  logic [62:0]     period_budget,
   input  logic [31:0]     threshold,
   input  logic            throttled,
   input  logic [31:0]     overuse_tally,
   input  logic [62:0]     overuse_peak,
   output tbe_pkg::chk_type chk
);
   import tbe_pkg::*;

   logic [63:0] rem;
   logic        neg;
   logic        below;
   logic [63:0] over;
   logic [62:0] over_sat;

   // Remaining budget as a two's-complement value
   assign rem   = {1'b0, period_budget} - run_time;
   assign neg   = rem[63];
   assign below = neg || (rem < {32'b0, threshold});
   assign over  = 64'd0 - rem;
   assign over_sat = over[63] ? {63{1'b1}} : over[62:0];

   always_comb begin
      chk.overuse_tally = overuse_tally;
      chk.overuse_peak  = overuse_peak;
      // Overuse statistics only when the budget went negative
      if (below && neg) begin
         if ((over > {32'b0, threshold}) && (overuse_tally != '1)) begin
            chk.overuse_tally = overuse_tally + 32'd1;
         end
         if (over_sat > overuse_peak) begin
            chk.overuse_peak = over_sat;
         end
      end
      chk.throttle_set = below && !throttled;
      chk.sleep_req    = below && !throttled;
      chk.remaining    = below ? 63'd0 : rem[62:0];
      chk.timer_arm    = !below && (rem != 64'd0);
      chk.timer_reload = chk.timer_arm ?
                         (rem[62:0] - {32'b0, threshold[31:1]}) : 63'd0;
   end

endmodule

// ----- hdl/tbe_core.sv -----
// ---------------------------------------------------------------------------
// tbe_core
// Task accounting state and per-event update; one event per enabled cycle.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tbe_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  logic [2:0]       mode,
   input  logic [63:0]      now_time,
   input  logic [63:0]      now_count,
   input  logic             work_pending,
   input  logic [62:0]      period_budget,
   input  logic [31:0]      threshold,
   output tbe_pkg::rsp_type rsp
);
   import tbe_pkg::*;

   // Stamp and total slots: job, job2, activation for time, then for count
   localparam logic [2:0] IDX_JOB_T  = 3'd0;
   localparam logic [2:0] IDX_JOB2_T = 3'd1;
   localparam logic [2:0] IDX_ACT_T  = 3'd2;
   localparam logic [2:0] IDX_JOB_C  = 3'd3;
   localparam logic [2:0] IDX_JOB2_C = 3'd4;
   localparam logic [2:0] IDX_ACT_C  = 3'd5;

   logic        sleeping_ff, sleeping_in;
   logic        throttled_ff, throttled_in;
   logic [63:0] stamp_ff [6];
   logic [63:0] stamp_in [6];
   logic [63:0] acc_ff [6];
   logic [63:0] acc_in [6];
   logic [63:0] ctime_ff, ctime_in;
   logic [63:0] ccount_ff, ccount_in;
   logic [31:0] ocount_ff, ocount_in;
   logic [62:0] opeak_ff, opeak_in;

   logic        do_check;
   logic        delta_on;
   logic        sreq;
   logic        wreq;
   logic [63:0] job_run;
   logic [63:0] job_cnt;
   logic [63:0] pused;
   logic [63:0] run_time;
   logic [63:0] act_delta;
   chk_type     chk;

   assign act_delta = now_time - stamp_ff[IDX_ACT_T];
   assign run_time  = acc_ff[IDX_ACT_T] + (delta_on ? act_delta : 64'd0);

   tbe_budget_check u_check (
      .run_time      (run_time),
      .period_budget (period_budget),
      .threshold     (threshold),
      .throttled     (throttled_ff),
      .overuse_tally (ocount_ff),
      .overuse_peak  (opeak_ff),
      .chk           (chk)
   );

   // Per-mode next state
   always_comb begin
      stamp_in     = stamp_ff;
      acc_in       = acc_ff;
      sleeping_in  = sleeping_ff;
      throttled_in = throttled_ff;
      ctime_in     = ctime_ff;
      ccount_in    = ccount_ff;
      ocount_in    = ocount_ff;
      opeak_in     = opeak_ff;
      job_run      = 64'd0;
      job_cnt      = 64'd0;
      pused        = 64'd0;
      sreq         = 1'b0;
      wreq         = 1'b0;
      do_check     = 1'b0;
      delta_on     = 1'b0;
      case (mode_type'(mode))
         MODE_FIRST_JOB: begin
            for (int i = 0; i < 3; i++) begin
               acc_in[i]       = 64'd0;
               acc_in[i + 3]   = 64'd0;
               stamp_in[i]     = now_time;
               stamp_in[i + 3] = now_count;
            end
         end
         MODE_BOUNDARY_SLEEP: begin
            job_run = now_time - stamp_ff[IDX_JOB_T] + acc_ff[IDX_JOB_T];
            job_cnt = now_count - stamp_ff[IDX_JOB_C] + acc_ff[IDX_JOB_C];
            pused   = act_delta;
            acc_in[IDX_JOB_T]   = 64'd0;
            acc_in[IDX_JOB_C]   = 64'd0;
            stamp_in[IDX_JOB_T] = now_time;
            stamp_in[IDX_JOB_C] = now_count;
         end
         MODE_BOUNDARY_PREDICT: begin
            job_run = now_time - stamp_ff[IDX_JOB2_T] + acc_ff[IDX_JOB2_T];
            job_cnt = now_count - stamp_ff[IDX_JOB2_C] + acc_ff[IDX_JOB2_C];
            acc_in[IDX_JOB2_T]   = 64'd0;
            acc_in[IDX_JOB2_C]   = 64'd0;
            stamp_in[IDX_JOB2_T] = now_time;
            stamp_in[IDX_JOB2_C] = now_count;
         end
         MODE_SCHED_IN: begin
            if (throttled_ff) begin
               sreq = 1'b1;
            end else begin
               for (int i = 0; i < 3; i++) begin
                  stamp_in[i]     = now_time;
                  stamp_in[i + 3] = now_count;
               end
               sleeping_in = 1'b0;
               do_check    = 1'b1;
            end
         end
         MODE_SCHED_OUT: begin
            if (!sleeping_ff) begin
               for (int i = 0; i < 3; i++) begin
                  acc_in[i]     = acc_ff[i] + (now_time - stamp_ff[i]);
                  acc_in[i + 3] = acc_ff[i + 3] + (now_count - stamp_ff[i + 3]);
               end
               sleeping_in = 1'b1;
            end
         end
         MODE_CHECK: begin
            do_check = 1'b1;
            delta_on = !sleeping_ff;
         end
         MODE_REFRESH: begin
            job_run = acc_ff[IDX_JOB_T] +
                      (sleeping_ff ? 64'd0 : (now_time - stamp_ff[IDX_JOB_T]));
            ctime_in  = ctime_ff + acc_ff[IDX_ACT_T];
            ccount_in = ccount_ff + acc_ff[IDX_ACT_C];
            acc_in[IDX_ACT_T] = 64'd0;
            acc_in[IDX_ACT_C] = 64'd0;
            if (throttled_ff) begin
               throttled_in = 1'b0;
               wreq         = work_pending;
            end
         end
         default: begin
         end
      endcase

      // Apply the budget check where the mode asks for one
      if (do_check) begin
         ocount_in    = chk.overuse_tally;
         opeak_in     = chk.overuse_peak;
         sreq         = chk.sleep_req;
         throttled_in = throttled_ff | chk.throttle_set;
      end
   end

   // Result of this event, taken with the post-event flags and statistics
   always_comb begin
      rsp.remaining_budget   = do_check ? chk.remaining : 63'd0;
      rsp.timer_arm          = do_check && chk.timer_arm;
      rsp.timer_reload       = do_check ? chk.timer_reload : 63'd0;
      rsp.sleep_request      = sreq;
      rsp.wake_request       = wreq;
      rsp.throttled          = throttled_in;
      rsp.job_runtime        = job_run;
      rsp.job_count_used     = job_cnt;
      rsp.period_used_so_far = pused;
      rsp.consumed_total     = ctime_in;
      rsp.overuse_events     = ocount_in;
      rsp.worst_overuse      = opeak_in;
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sleeping_ff  <= 1'b1;
         throttled_ff <= 1'b0;
         ctime_ff     <= 64'd0;
         ccount_ff    <= 64'd0;
         ocount_ff    <= 32'd0;
         opeak_ff     <= 63'd0;
         for (int i = 0; i < 6; i++) begin
            stamp_ff[i] <= 64'd0;
            acc_ff[i]   <= 64'd0;
         end
      end else if (fire) begin
         sleeping_ff  <= sleeping_in;
         throttled_ff <= throttled_in;
         ctime_ff     <= ctime_in;
         ccount_ff    <= ccount_in;
         ocount_ff    <= ocount_in;
         opeak_ff     <= opeak_in;
         stamp_ff     <= stamp_in;
         acc_ff       <= acc_in;
      end
   end

   `ASSERT_NEXT(a_refresh_unthrottles, fire && (mode == MODE_REFRESH), !throttled_ff, "refresh left task throttled")
   `ASSERT_NEXT(a_sched_out_sleeps, fire && (mode == MODE_SCHED_OUT), sleeping_ff, "sched out left task running")
   `ASSERT_NEXT(a_sched_in_runs, fire && (mode == MODE_SCHED_IN) && !throttled_ff, !sleeping_ff, "sched in left task asleep")

endmodule
